[rtl/core/mwrd_pkg.sv]
// Shared types, codes and sizes for the Modbus write request decoder.
package mwrd_pkg;

   localparam int MAX_FRAME_BYTES = 260;
   localparam int POS_W = 9;
   localparam int CNT_W = 17;
   localparam int CSR_IDX_W = 1;
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_COIL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_COUNT  = 1'b1;

   localparam logic [1:0] KIND_COIL   = 2'd0;
   localparam logic [1:0] KIND_REG    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_READ      = 3'd2;
   localparam logic [2:0] ST_UNHANDLED = 3'd3;
   localparam logic [2:0] ST_SHORT     = 3'd4;

   localparam logic [7:0] FC_READ_FIRST  = 8'd1;
   localparam logic [7:0] FC_READ_LAST   = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
   localparam logic [7:0] FC_WRITE_REG   = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

   localparam logic [7:0] COIL_ON = 8'hFF;

   localparam logic [POS_W-1:0] POS_FUNC     = 9'd7;
   localparam logic [POS_W-1:0] POS_ADDR_HI  = 9'd8;
   localparam logic [POS_W-1:0] POS_ADDR_LO  = 9'd9;
   localparam logic [POS_W-1:0] POS_QTY_HI   = 9'd10;
   localparam logic [POS_W-1:0] POS_QTY_LO   = 9'd11;
   localparam logic [POS_W-1:0] POS_BYTE_CNT = 9'd12;
   localparam logic [POS_W-1:0] POS_DATA     = 9'd13;

   localparam logic [9:0] NEED_COIL = 10'd11;
   localparam logic [9:0] NEED_REG  = 10'd12;
   localparam logic [9:0] NEED_MULTI = 10'd13;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [15:0] target_address;
      logic [15:0] write_value;
      logic [2:0]  frame_status;
      logic [7:0]  func_code;
      logic        run_last;
   } rsp_type;

   // One accepted byte's work: up to eight writes, then an optional status beat.
   typedef struct packed {
      logic [3:0]  wr_cnt;
      logic        wr_multi;
      logic [1:0]  wr_kind;
      logic [15:0] wr_addr;
      logic [15:0] wr_value;
      logic        st_valid;
      logic [2:0]  st;
      logic [7:0]  fc;
   } job_type;

endpackage

[rtl/core/mwrd_front.sv]
// Front end: tracks the frame, range-checks addresses and issues write and status jobs.
module mwrd_front
   import mwrd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   input  logic             q_full,
   input  logic [CNT_W-1:0] coil_count,
   input  logic [CNT_W-1:0] register_count,
   output logic             req_full,
   output logic             job_push,
   output job_type          job
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       fc_ff, fc_in;
   logic [15:0]      start_ff, start_in;
   logic [15:0]      qty_ff, qty_in;
   logic [7:0]       dbc_ff, dbc_in;
   logic             rok_ff, rok_in;
   logic [7:0]       hi_ff, hi_in;

   logic             accept;
   logic             take;
   logic [POS_W-1:0] off;
   logic [11:0]      base;
   logic [15:0]      diff;
   logic [7:0]       ridx;
   logic [13:0]      q7;
   logic [7:0]       nb;
   logic [7:0]       nr;
   logic [7:0]       nr_min;
   logic [9:0]       need;
   logic [2:0]       status;
   logic [7:0]       b;
   job_type          job_w;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign b        = req_data.frame_byte;
   assign take     = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign off      = pos_ff - POS_DATA;
   assign base     = {off, 3'b000};
   assign diff     = qty_ff - {4'b0, base};
   assign ridx     = off[8:1];

   always_comb begin
      pos_in   = pos_ff;
      fc_in    = fc_ff;
      start_in = start_ff;
      qty_in   = qty_ff;
      dbc_in   = dbc_ff;
      rok_in   = rok_ff;
      hi_in    = hi_ff;
      job_w         = '0;
      job_w.wr_kind = KIND_COIL;
      if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff == POS_FUNC) begin
            fc_in = b;
         end else if (pos_ff == POS_ADDR_HI) begin
            start_in = {b, 8'h00};
         end else if (pos_ff == POS_ADDR_LO) begin
            start_in = {start_ff[15:8], b};
            if (fc_ff == FC_WRITE_COIL) rok_in = {1'b0, start_in} < coil_count;
            if (fc_ff == FC_WRITE_REG) rok_in = {1'b0, start_in} < register_count;
         end else if (pos_ff == POS_QTY_HI) begin
            qty_in = {b, 8'h00};
            if (fc_ff == FC_WRITE_COIL && rok_ff) begin
               job_w.wr_cnt   = 4'd1;
               job_w.wr_kind  = KIND_COIL;
               job_w.wr_addr  = start_ff;
               job_w.wr_value = {15'b0, b == COIL_ON};
            end
         end else if (pos_ff == POS_QTY_LO) begin
            qty_in = {qty_ff[15:8], b};
            if (fc_ff == FC_WRITE_REG && rok_ff) begin
               job_w.wr_cnt   = 4'd1;
               job_w.wr_kind  = KIND_REG;
               job_w.wr_addr  = start_ff;
               job_w.wr_value = qty_in;
            end
            if (fc_ff == FC_WRITE_COILS)
               rok_in = ({1'b0, start_ff} + {1'b0, qty_in}) <= coil_count;
            if (fc_ff == FC_WRITE_REGS)
               rok_in = ({1'b0, start_ff} + {1'b0, qty_in}) <= register_count;
         end else if (pos_ff == POS_BYTE_CNT) begin
            dbc_in = b;
         end else if (pos_ff >= POS_DATA) begin
            if (fc_ff == FC_WRITE_COILS && rok_ff && off < {1'b0, dbc_ff}) begin
               if (qty_ff > {4'b0, base}) begin
                  job_w.wr_cnt   = (diff >= 16'd8) ? 4'd8 : diff[3:0];
                  job_w.wr_multi = 1'b1;
                  job_w.wr_kind  = KIND_COIL;
                  job_w.wr_addr  = start_ff + {4'b0, base};
                  job_w.wr_value = {8'h00, b};
               end
            end else if (fc_ff == FC_WRITE_REGS && rok_ff) begin
               if (!off[0]) begin
                  hi_in = b;
               end else if ({8'b0, ridx} < qty_ff && {ridx, 1'b0} < {1'b0, dbc_ff}) begin
                  job_w.wr_cnt   = 4'd1;
                  job_w.wr_kind  = KIND_REG;
                  job_w.wr_addr  = start_ff + {8'b0, ridx};
                  job_w.wr_value = {hi_ff, b};
               end
            end
         end
      end
      job_w.fc = fc_in;
   end

   // Frame status from the state as it stands after this byte.
   always_comb begin
      q7     = 14'(({1'b0, qty_in} + 17'd7) >> 3);
      nb     = (q7 > {6'b0, dbc_in}) ? dbc_in : q7[7:0];
      nr     = 8'(({1'b0, dbc_in} + 9'd1) >> 1);
      nr_min = ({8'b0, nr} > qty_in) ? qty_in[7:0] : nr;
      need   = 10'd0;
      status = ST_DONE;
      if (pos_in < POS_ADDR_HI) begin
         status = ST_SHORT;
      end else if (fc_in >= FC_READ_FIRST && fc_in <= FC_READ_LAST) begin
         status = ST_READ;
      end else if (fc_in == FC_WRITE_COIL || fc_in == FC_WRITE_REG ||
                   fc_in == FC_WRITE_COILS || fc_in == FC_WRITE_REGS) begin
         if (fc_in == FC_WRITE_COIL) need = NEED_COIL;
         else if (fc_in == FC_WRITE_REG) need = NEED_REG;
         else if (fc_in == FC_WRITE_COILS) need = NEED_MULTI + (rok_in ? {2'b0, nb} : 10'd0);
         else need = NEED_MULTI + (rok_in ? {1'b0, nr_min, 1'b0} : 10'd0);
         if ({1'b0, pos_in} < need) status = ST_SHORT;
         else status = rok_in ? ST_DONE : ST_RANGE;
      end else begin
         status = ST_UNHANDLED;
      end
   end

   always_comb begin
      job_push = accept && (job_w.wr_cnt != 4'd0 || req_data.frame_end);
   end

   always_comb begin
      job          = job_w;
      job.st_valid = req_data.frame_end;
      job.st       = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fc_ff    <= '0;
         start_ff <= '0;
         qty_ff   <= '0;
         dbc_ff   <= '0;
         rok_ff   <= 1'b0;
         hi_ff    <= '0;
      end else if (accept) begin
         if (req_data.frame_end) begin
            pos_ff   <= '0;
            fc_ff    <= '0;
            start_ff <= '0;
            qty_ff   <= '0;
            dbc_ff   <= '0;
            rok_ff   <= 1'b0;
            hi_ff    <= '0;
         end else begin
            pos_ff   <= pos_in;
            fc_ff    <= fc_in;
            start_ff <= start_in;
            qty_ff   <= qty_in;
            dbc_ff   <= dbc_in;
            rok_ff   <= rok_in;
            hi_ff    <= hi_in;
         end
      end
   end

endmodule

[rtl/core/mwrd_jobq.sv]
// Short job queue between the front end and the result expander.
module mwrd_jobq
   import mwrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type              mem_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0] wr_ff, wr_in;
   logic [JOBQ_PTR_W-1:0] rd_ff, rd_in;
   logic [JOBQ_PTR_W:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full    = cnt_ff == (JOBQ_PTR_W+1)'(JOBQ_DEPTH);
   assign empty   = cnt_ff == '0;
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? JOBQ_PTR_W'((32'(wr_ff) + 1) % JOBQ_DEPTH) : wr_ff;
      rd_in  = do_pop ? JOBQ_PTR_W'((32'(rd_ff) + 1) % JOBQ_DEPTH) : rd_ff;
      cnt_in = cnt_ff + {{JOBQ_PTR_W{1'b0}}, do_push} - {{JOBQ_PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

[rtl/core/mwrd_back.sv]
// Back end: expands each job into result beats through an output register.
module mwrd_back
   import mwrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type job,
   input  logic    job_empty,
   output logic    job_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   logic [3:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       last;
   logic [3:0] total;

   assign rsp_empty = !vld_ff;
   assign rsp_data  = rsp_ff;
   assign load      = !job_empty && (!vld_ff || rsp_pop);
   assign total     = job.wr_cnt + {3'b0, job.st_valid};
   assign last      = idx_ff == total - 4'd1;
   assign job_pop   = load && last;

   always_comb begin
      rsp_in           = '0;
      rsp_in.func_code = job.fc;
      rsp_in.run_last  = last;
      if (idx_ff < job.wr_cnt) begin
         rsp_in.item_kind      = job.wr_kind;
         rsp_in.target_address = job.wr_addr + {12'b0, idx_ff};
         rsp_in.write_value    = job.wr_multi ? {15'b0, job.wr_value[idx_ff]} : job.wr_value;
         rsp_in.frame_status   = ST_DONE;
      end else begin
         rsp_in.item_kind    = KIND_STATUS;
         rsp_in.frame_status = job.st;
      end
      idx_in = idx_ff;
      if (load) idx_in = last ? 4'd0 : idx_ff + 4'd1;
      vld_in = load ? 1'b1 : (rsp_pop ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

endmodule

[rtl/core/modbus_write_request_decoder.sv]
// Top level of the Modbus TCP write request decoder.
// A byte's result beats pass through the job queue and then the output register.
// Throughput: one request byte per cycle while the four-entry job queue has room;
// results leave at one beat per cycle while popped, a coil data byte taking up to
// eight beats and the frame end one more, so the result side sets the sustained rate.
// Reset: synchronous; clears frame state, both count registers and all queues.
module modbus_write_request_decoder
   import mwrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   logic [CNT_W-1:0] coil_cnt_ff, coil_cnt_in;
   logic [CNT_W-1:0] reg_cnt_ff, reg_cnt_in;
   logic             q_full, q_empty, q_push, q_pop;
   job_type          q_in, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      coil_cnt_in = coil_cnt_ff;
      reg_cnt_in  = reg_cnt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COIL_COUNT: coil_cnt_in = csr_data;
            CSR_REG_COUNT:  reg_cnt_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coil_cnt_ff <= '0;
         reg_cnt_ff  <= '0;
      end else begin
         coil_cnt_ff <= coil_cnt_in;
         reg_cnt_ff  <= reg_cnt_in;
      end
   end

   mwrd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data       (req_data),
      .q_full         (q_full),
      .coil_count     (coil_cnt_ff),
      .register_count (reg_cnt_ff),
      .req_full       (req_full),
      .job_push       (q_push),
      .job            (q_in)
   );

   mwrd_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   mwrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (q_head),
      .job_empty (q_empty),
      .job_pop   (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/mwrd_checker.sv]
// Port-level checks for the Modbus write request decoder, bound to the top level.
module mwrd_checker
   import mwrd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result beat changed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.item_kind == KIND_STATUS |->
         rsp_data.run_last && rsp_data.target_address == 16'd0 &&
         rsp_data.write_value == 16'd0)
      else $error("status beat malformed");

   a_write_beat: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.item_kind != KIND_STATUS |->
         (rsp_data.item_kind == KIND_COIL || rsp_data.item_kind == KIND_REG) &&
         rsp_data.frame_status == ST_DONE)
      else $error("write beat malformed");

   a_coil_bit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.item_kind == KIND_COIL |-> rsp_data.write_value[15:1] == 15'd0)
      else $error("coil value wider than one bit");

endmodule

bind modbus_write_request_decoder mwrd_checker u_mwrd_checker (.*);
